>>> hdl/fswm_pkg.sv
// Shared types, constants and helpers for the fixed string window matcher.
// No dependencies; imported by every module of the block.
package fswm_pkg;

    localparam int BYTE_W        = 8;
    localparam int PATTERN_BYTES = 16;
    localparam int PATTERN_W     = PATTERN_BYTES * BYTE_W;
    localparam int HALF_W        = 64;
    localparam int LEN_W         = 5;
    localparam int LIMIT_W       = 16;
    localparam int POS_W         = 17;
    localparam int IDX_W         = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [LEN_W-1:0]     length;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic [LIMIT_W-1:0] limit;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } result_t;

    // Pattern byte at a given index; bytes past the stored pattern read as zero.
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [PATTERN_W-1:0] pattern,
        input logic [IDX_W-1:0]     idx
    );
        logic [BYTE_W-1:0] sel;
        sel = '0;
        for (int e = 0; e < PATTERN_BYTES; e++) begin
            if (idx == IDX_W'(e))
            begin
                sel = pattern[e*BYTE_W +: BYTE_W];
            end
        end
        return sel;
    endfunction

endpackage

>>> hdl/fswm_cfg.sv
// Configuration registers of the window matcher: pattern bytes and length.
// Depends on fswm_pkg.
module fswm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [fswm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fswm_pkg::CFG_DATA_W-1:0] cfg_data,
    output fswm_pkg::cfg_t                  cfg
);
    import fswm_pkg::*;

    logic [HALF_W-1:0] pattern_low_reg,    pattern_low_next;
    logic [HALF_W-1:0] pattern_high_reg,   pattern_high_next;
    logic [LEN_W-1:0]  pattern_length_reg, pattern_length_next;

    always_comb
    begin
        pattern_low_next    = pattern_low_reg;
        pattern_high_next   = pattern_high_reg;
        pattern_length_next = pattern_length_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_next    = cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_next   = cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_next = cfg_data[LEN_W-1:0];
                default:            ; // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= LEN_W'(1);
        end
        else
        begin
            pattern_low_reg    <= pattern_low_next;
            pattern_high_reg   <= pattern_high_next;
            pattern_length_reg <= pattern_length_next;
        end
    end

    assign cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cfg.length  = pattern_length_reg;

endmodule

>>> hdl/fswm_search.sv
// Search stage: byte window, parallel pattern compare and per-search state.
// Depends on fswm_pkg.
module fswm_search #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int MAX_TEXT_BYTES    = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              step,
    input  fswm_pkg::item_t   item,
    input  fswm_pkg::cfg_t    cfg,
    output logic              result_valid,
    output fswm_pkg::result_t result
);
    import fswm_pkg::*;

    localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam int AL_W  = $clog2(MAX_PATTERN_BYTES + 1);

    logic [BYTE_W-1:0]  window_reg [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0]  win_shift  [MAX_PATTERN_BYTES];
    logic [CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [LIMIT_W-1:0] held_limit_reg, held_limit_next;
    logic               search_done_reg, search_done_next;

    logic [AL_W-1:0]              act_len;
    logic                         first;
    logic [LIMIT_W-1:0]           lim;
    logic                         active;
    logic [CNT_W-1:0]             cnt_inc;
    logic [CNT_W-1:0]             cnt_after;
    logic [MAX_PATTERN_BYTES-1:0] byte_ok;
    logic                         window_hit;
    logic                         ge;
    logic [31:0]                  start;
    logic                         hit;
    logic                         early;
    logic                         done_after;
    logic                         tail_fail;

    // Clamp the configured length to 1..MAX_PATTERN_BYTES
    always_comb
    begin
        if (cfg.length == '0)
        begin
            act_len = AL_W'(1);
        end
        else if (int'(cfg.length) > MAX_PATTERN_BYTES)
        begin
            act_len = AL_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            act_len = AL_W'(cfg.length);
        end
    end

    assign first   = (byte_count_reg == '0) && !search_done_reg;
    assign lim     = first ? item.limit : held_limit_reg;
    assign active  = !search_done_reg && (32'(byte_count_reg) < 32'(MAX_TEXT_BYTES));
    assign cnt_inc = byte_count_reg + CNT_W'(1);

    always_comb
    begin
        win_shift[0] = item.data;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
        begin
            win_shift[i] = window_reg[i-1];
        end
    end

    // Window slot k (0 = newest) lines up with pattern byte act_len-1-k
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            byte_ok[k] = (k >= int'(act_len))
                || (win_shift[k] == pattern_byte(cfg.pattern,
                       IDX_W'(act_len) - IDX_W'(1) - IDX_W'(k)));
        end
    end

    assign window_hit = &byte_ok;
    assign ge         = 32'(cnt_inc) >= 32'(act_len);
    assign start      = 32'(cnt_inc) - 32'(act_len);
    assign hit        = active && ge && (start <= 32'(lim)) && window_hit;
    assign early      = active && ge && !hit && (start >= 32'(lim));
    assign done_after = search_done_reg || hit || early;
    assign cnt_after  = active ? cnt_inc : byte_count_reg;
    assign tail_fail  = item.last && !done_after;

    assign result_valid = item_valid && (hit || early || tail_fail);

    always_comb
    begin
        result.found = hit;
        priority if (hit)
        begin
            result.position = POS_W'(cnt_inc);
        end
        else if (early)
        begin
            result.position = POS_W'(lim);
        end
        else if (32'(cnt_after) >= 32'(act_len))
        begin
            result.position = POS_W'(32'(cnt_after) - 32'(act_len) + 32'd1);
        end
        else
        begin
            result.position = '0;
        end
    end

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        held_limit_next  = held_limit_reg;
        search_done_next = search_done_reg;
        if (step)
        begin
            if (first)
            begin
                held_limit_next = item.limit;
            end
            byte_count_next  = cnt_after;
            search_done_next = done_after;
            // last byte closes the search whatever happened before
            if (item.last)
            begin
                byte_count_next  = '0;
                search_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            held_limit_reg  <= '0;
            search_done_reg <= 1'b0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            held_limit_reg  <= held_limit_next;
            search_done_reg <= search_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && active)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                window_reg[i] <= win_shift[i];
            end
        end
    end

endmodule

>>> hdl/fixed_string_window_matcher_core.sv
// Top level of the fixed string window matcher: input register, search stage,
// result register. Depends on fswm_pkg, fswm_cfg and fswm_search.
//
// Text bytes enter one per transfer, with the final byte of each text marked;
// one result comes out per search, via the input and result registers. The
// block takes one byte every cycle unless stalled; the window shift and the
// compare of all pattern positions settle combinationally between the input
// register and the result register. The input stalls only while a result
// sits in the output register under stall and the held byte would produce
// another one. Write the pattern registers only while no search is in flight.
module fixed_string_window_matcher_core #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int MAX_TEXT_BYTES    = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fswm_pkg::BYTE_W-1:0]     text_byte,
    input  logic                            last_byte,
    input  logic [fswm_pkg::LIMIT_W-1:0]    start_limit,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [fswm_pkg::POS_W-1:0]      position,
    input  logic                            cfg_write_en,
    input  logic [fswm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fswm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fswm_pkg::*;

    cfg_t    cfg;
    item_t   item_reg, item_next;
    logic    item_valid_reg, item_valid_next;
    result_t result_reg, result_next;
    logic    out_valid_reg, out_valid_next;
    result_t result;
    logic    result_valid;
    logic    out_free;
    logic    advance;
    logic    in_xfer;

    fswm_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    fswm_search #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .MAX_TEXT_BYTES    (MAX_TEXT_BYTES)
    ) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid_reg),
        .step         (advance),
        .item         (item_reg),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result       (result)
    );

    // A byte that gives no result moves on even while the output is stalled
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = item_valid_reg && (out_free || !result_valid);
    assign in_stall = item_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        item_next       = item_reg;
        item_valid_next = item_valid_reg && !advance;
        if (in_xfer)
        begin
            item_next.data  = text_byte;
            item_next.last  = last_byte;
            item_next.limit = start_limit;
            item_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance && result_valid)
        begin
            result_next    = result;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = result_reg.found;
    assign position  = result_reg.position;

endmodule

>>> hdl/fswm_checker.sv
// Port-level checks for the window matcher, bound to the top level.
// Depends on fswm_pkg and fixed_string_window_matcher_core.
module fswm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       found,
    input logic [fswm_pkg::POS_W-1:0] position
);
    import fswm_pkg::*;

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(position))
        else $error("stalled result changed");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // no new result without a byte in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !$past(in_valid) && !$past(in_stall) |=> !out_valid)
        else $error("result without a transfer behind it");

endmodule

bind fixed_string_window_matcher_core fswm_checker u_fswm_checker (.*);

>>> verif/tb.sv
// Testbench for fixed_string_window_matcher_core: directed and random search texts
// checked against a cycle-free predictor of the window search. Depends on fswm_pkg.
module tb;
    import fswm_pkg::*;

    localparam int CLOCK_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 300;
    localparam int TEXT_CAP      = 65536;
    localparam int RANDOM_BYTES  = 1500;
    localparam int LONG_TEXT     = 200;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     text_byte;
    logic                  last_byte;
    logic [LIMIT_W-1:0]    start_limit;
    logic                  out_valid;
    logic                  out_stall;
    logic                  found;
    logic [POS_W-1:0]      position;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of configuration and search state
    logic [HALF_W-1:0] pat_lo_q = '0;
    logic [HALF_W-1:0] pat_hi_q = '0;
    logic [LEN_W-1:0]  pat_len_q = 5'd1;
    logic [BYTE_W-1:0] window_q [PATTERN_BYTES];
    int unsigned       text_len_q = 0;
    int unsigned       held_limit_q = 0;
    bit                search_over_q = 1'b0;
    result_t           results_due [$];

    logic [BYTE_W-1:0] text_buf [$];
    result_t           due_r;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                bytes_sent = 0;
    int                fail_count = 0;
    int                cycle_count = 0;
    int                hold_requested = 0;
    int                hold_served = 0;

    fixed_string_window_matcher_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .start_limit  (start_limit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .position     (position),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            window_q[k] = '0;
        end
    end

    function automatic int unsigned effective_length();
        if (pat_len_q == 0)
        begin
            return 1;
        end
        if (pat_len_q > PATTERN_BYTES)
        begin
            return PATTERN_BYTES;
        end
        return pat_len_q;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_at(input int unsigned j);
        logic [PATTERN_W-1:0] whole;
        whole = {pat_hi_q, pat_lo_q};
        return whole[8*j +: 8];
    endfunction

    // Oldest byte of the window lines up with pattern byte 0
    function automatic bit window_hit(input int unsigned n);
        for (int unsigned j = 0; j < n; j++)
        begin
            if (window_q[n - 1 - j] != pattern_at(j))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void queue_result(input bit f, input int unsigned pos);
        result_t r;
        r.found    = f;
        r.position = POS_W'(pos);
        results_due.push_back(r);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_symbol();
        if ($urandom_range(99) < 85)
        begin
            return 8'h41 + 8'($urandom_range(2));
        end
        return 8'($urandom);
    endfunction

    // Advance the search state by one accepted byte
    function automatic void track_search(input logic [BYTE_W-1:0] b, input logic lst,
                                         input logic [LIMIT_W-1:0] lim);
        int unsigned n;
        int unsigned first;
        n = effective_length();
        if (text_len_q == 0 && !search_over_q)
        begin
            held_limit_q = lim;
        end
        if (!search_over_q && text_len_q < TEXT_CAP)
        begin
            for (int k = PATTERN_BYTES - 1; k > 0; k--)
            begin
                window_q[k] = window_q[k - 1];
            end
            window_q[0] = b;
            text_len_q++;
            if (text_len_q >= n)
            begin
                first = text_len_q - n;
                if (first <= held_limit_q && window_hit(n))
                begin
                    queue_result(1'b1, text_len_q);
                    search_over_q = 1'b1;
                end
                else if (first >= held_limit_q)
                begin
                    queue_result(1'b0, held_limit_q);
                    search_over_q = 1'b1;
                end
            end
        end
        if (lst)
        begin
            if (!search_over_q)
            begin
                queue_result(1'b0, (text_len_q >= n) ? text_len_q - n + 1 : 0);
            end
            text_len_q    = 0;
            search_over_q = 1'b0;
        end
    endfunction

    task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic lst,
                              input logic [LIMIT_W-1:0] lim);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        last_byte   <= lst;
        start_limit <= lim;
        do
            @(posedge clk);
        while (in_stall);
        track_search(b, lst, lim);
        bytes_sent++;
    endtask

    // Limit matters on the first byte only; scramble it on the rest
    task automatic send_text(input logic [LIMIT_W-1:0] lim);
        for (int k = 0; k < text_buf.size(); k++)
        begin
            offer_byte(text_buf[k], k == text_buf.size() - 1,
                       (k == 0) ? lim : 16'($urandom));
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_PATTERN_LOW:    pat_lo_q = val;
            CFG_PATTERN_HIGH:   pat_hi_q = val;
            CFG_PATTERN_LENGTH: pat_len_q = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_pattern(input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi,
                               input logic [CFG_DATA_W-1:0] len_word);
        write_register(CFG_PATTERN_LOW, lo);
        write_register(CFG_PATTERN_HIGH, hi);
        write_register(CFG_PATTERN_LENGTH, len_word);
    endtask

    // Reset pattern is a single zero byte; an early miss drops the rest of the text
    task automatic test_reset_state();
        text_buf = '{8'h07, 8'h00, 8'hFF};
        send_text(16'h0000);
        wait_idle();
    endtask

    task automatic test_extreme_bytes();
        set_pattern(64'h0000_0000_0000_00FF, '0, 64'd1);
        text_buf = '{8'h00, 8'hFF};
        send_text(16'hFFFF);
        wait_idle();
    endtask

    task automatic test_full_pattern();
        set_pattern(64'hF0E1_D2C3_B4A5_9687, 64'h0F1E_2D3C_4B5A_6978, 64'd16);
        text_buf.delete();
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            text_buf.push_back(pattern_at(k));
        end
        send_text(16'h0000);
        wait_idle();
    endtask

    // Length 0 behaves as 1, lengths past 16 as 16
    task automatic test_length_bounds();
        set_pattern(64'h0000_0000_0000_0087, '0, 64'd0);
        text_buf = '{8'h87};
        send_text(16'h0000);
        wait_idle();
        write_register(CFG_PATTERN_LENGTH, 64'd31);
        text_buf = '{8'h00};
        send_text(16'hFFFF);
        wait_idle();
    endtask

    task automatic test_length_change_mid_text();
        set_pattern(64'h0000_0000_0000_4343, '0, 64'd2);
        offer_byte(8'h41, 1'b0, 16'hFFFF);
        offer_byte(8'h42, 1'b0, 16'h1234);
        wait_idle();
        write_register(CFG_PATTERN_LENGTH, 64'd1);
        offer_byte(8'h43, 1'b1, 16'h0000);
        wait_idle();
    endtask

    task automatic run_random_texts(input int target, input int sender_pct,
                                    input int receiver_pct);
        int                   first_count;
        int                   texts;
        int                   r;
        bit                   noise;
        int unsigned          tlen;
        int unsigned          plen;
        int unsigned          at;
        int unsigned          keep;
        logic [PATTERN_W-1:0] pat;
        logic [CFG_DATA_W-1:0] len_word;
        logic [LIMIT_W-1:0]   lim;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        first_count   = bytes_sent;
        texts         = 0;
        while (bytes_sent - first_count < target)
        begin
            if (texts % 30 == 0)
            begin
                wait_idle();
                for (int k = 0; k < PATTERN_BYTES; k++)
                begin
                    pat[8*k +: 8] = pick_symbol();
                end
                len_word = {$urandom, $urandom};
                r = $urandom_range(99);
                if (r < 3)
                    len_word[LEN_W-1:0] = 5'd0;
                else if (r < 8)
                    len_word[LEN_W-1:0] = 5'($urandom_range(17, 31));
                else if (r < 75)
                    len_word[LEN_W-1:0] = 5'($urandom_range(1, 4));
                else
                    len_word[LEN_W-1:0] = 5'($urandom_range(5, 16));
                set_pattern(pat[HALF_W-1:0], pat[PATTERN_W-1:HALF_W], len_word);
            end
            text_buf.delete();
            tlen  = ($urandom_range(99) < 80) ? $urandom_range(1, 24) : $urandom_range(25, 80);
            noise = ($urandom_range(99) < 10);
            for (int unsigned k = 0; k < tlen; k++)
            begin
                text_buf.push_back(noise ? 8'($urandom) : pick_symbol());
            end
            plen = effective_length();
            if (!noise && plen <= tlen && $urandom_range(99) < 60)
            begin
                at = $urandom_range(0, tlen - plen);
                // a partial copy leaves a near miss
                keep = ($urandom_range(3) == 0) ? $urandom_range(0, plen - 1) : plen;
                for (int unsigned k = 0; k < keep; k++)
                begin
                    text_buf[at + k] = pattern_at(k);
                end
            end
            r = $urandom_range(99);
            if (r < 45)
                lim = 16'hFFFF;
            else if (r < 80)
                lim = 16'($urandom_range(0, tlen));
            else
                lim = 16'($urandom);
            send_text(lim);
            texts++;
        end
        wait_idle();
    endtask

    // Every one-byte text yields a result, so a long hold fills the block
    task automatic test_receiver_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_pattern(64'h0000_0000_0000_00AA, '0, 64'd1);
        hold_requested++;
        for (int k = 0; k < 80; k++)
        begin
            text_buf = '{($urandom_range(1) == 0) ? 8'hAA : 8'($urandom)};
            send_text(16'($urandom));
        end
        wait_idle();
    endtask

    task automatic test_long_texts();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // match on the final byte of a long text
        set_pattern(64'h0000_0000_0000_005A, '0, 64'd1);
        offer_byte(8'h00, 1'b0, 16'hFFFF);
        for (int k = 1; k < LONG_TEXT - 1; k++)
        begin
            offer_byte(8'h00, 1'b0, 16'($urandom));
        end
        offer_byte(8'h5A, 1'b1, 16'($urandom));
        wait_idle();
        // full-length pattern never seen: resume offset near the end of the text
        set_pattern(64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111, 64'd16);
        offer_byte(8'h00, 1'b0, 16'hFFFF);
        for (int k = 1; k < LONG_TEXT - 1; k++)
        begin
            offer_byte(8'h00, 1'b0, 16'($urandom));
        end
        offer_byte(8'h11, 1'b1, 16'($urandom));
        wait_idle();
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requested)
            begin
                hold_served = hold_requested;
                repeat (LONG_HOLD)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: found %0d position %0d", found, position);
                fail_count++;
            end
            else
            begin
                due_r = results_due.pop_front();
                if (found !== due_r.found)
                begin
                    $error("found: expected %0d, actual %0d", due_r.found, found);
                    fail_count++;
                end
                if (position !== due_r.position)
                begin
                    $error("position: expected %0d, actual %0d", due_r.position, position);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CLOCK_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        text_byte    = '0;
        last_byte    = 1'b0;
        start_limit  = '0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_extreme_bytes();
        test_full_pattern();
        test_length_bounds();
        test_length_change_mid_text();
        run_random_texts(RANDOM_BYTES / 3, 17, 48);
        run_random_texts(RANDOM_BYTES / 3, 48, 17);
        run_random_texts(RANDOM_BYTES - 2 * (RANDOM_BYTES / 3), 0, 0);
        test_receiver_hold();
        test_long_texts();
        wait_idle();

        if (fail_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/fswm_pkg.sv
hdl/fswm_cfg.sv
hdl/fswm_search.sv
hdl/fixed_string_window_matcher_core.sv
hdl/fswm_checker.sv
verif/tb.sv
